FILE: rtl/core/markup_tag_nesting_checker_assert.svh
// assertion macros for the markup tag nesting checker
// expects clk and rst_n in the scope of the module that uses them
`ifndef MARKUP_TAG_NESTING_CHECKER_ASSERT_SVH
`define MARKUP_TAG_NESTING_CHECKER_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define MTNC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tag nesting checker assertion failed");

// consequent holds in the cycle after the antecedent
`define MTNC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tag nesting checker assertion failed");

`endif

FILE: rtl/core/mtnc_pkg.sv
// shared types, sizes and codes of the markup tag nesting checker
// no dependencies
package mtnc_pkg;

    // sizing
    localparam int BYTE_W      = 8;
    localparam int STATUS_W    = 3;
    localparam int DEPTH_W     = 7;
    localparam int STACK_DEPTH = 64;
    localparam int NAME_LEN    = 16;

    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int CI_W        = $clog2(NAME_LEN + 1);
    localparam int STORE_DEPTH = STACK_DEPTH * NAME_LEN;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    localparam logic [COUNT_W-1:0]  COUNT_FULL  = COUNT_W'(STACK_DEPTH);
    localparam logic [CI_W-1:0]     NAME_LEN_CI = CI_W'(NAME_LEN);
    localparam logic [STORE_AW-1:0] NAME_LEN_A  = STORE_AW'(NAME_LEN);

    // characters of interest
    localparam logic [BYTE_W-1:0] CH_LT    = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_GT    = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

    // parser phase
    typedef enum logic [2:0] {
        PH_OUTSIDE = 3'd0,
        PH_START   = 3'd1,
        PH_OPEN    = 3'd2,
        PH_CLOSE   = 3'd3,
        PH_SKIP    = 3'd4
    } phase_t;

    // document status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_MISMATCH    = 3'd1,
        ST_EMPTY_CLOSE = 3'd2,
        ST_UNCLOSED    = 3'd3,
        ST_CUT_OFF     = 3'd4,
        ST_OVERFLOW    = 3'd5
    } status_t;

    // write requests from the engine to the name memories
    typedef struct packed {
        logic                store_we;
        logic [STORE_AW-1:0] store_addr;
        logic [BYTE_W-1:0]   store_data;
        logic                len_we;
        logic [STACK_AW-1:0] len_addr;
        logic [CI_W-1:0]     len_data;
    } mtnc_wr_t;

    // read addresses for the next item
    typedef struct packed {
        logic [STORE_AW-1:0] store_addr;
        logic [STACK_AW-1:0] len_addr;
    } mtnc_rd_t;

    // one document result
    typedef struct packed {
        status_t             status;
        logic [DEPTH_W-1:0]  depth;
    } mtnc_res_t;

endpackage

FILE: rtl/core/mtnc_if.sv
// valid/ready channel interfaces for document bytes and results
// depends on mtnc_pkg
interface mtnc_in_if import mtnc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface mtnc_out_if import mtnc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [DEPTH_W-1:0]  open_depth;

    modport source (output valid, output status, output open_depth, input ready);
    modport sink   (input valid, input status, input open_depth, output ready);
endinterface

FILE: rtl/core/mtnc_ram.sv
// generic single-write, single-read memory with registered read data
// no dependencies
module mtnc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/mtnc_engine.sv
// per-byte parse engine: phase, stack count, name compare and error latch
// depends on mtnc_pkg and the assertion macro header
`include "markup_tag_nesting_checker_assert.svh"

module mtnc_engine import mtnc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              last,
    input  logic [BYTE_W-1:0] store_rd,
    input  logic [CI_W-1:0]   len_rd,
    output mtnc_wr_t          wr,
    output mtnc_rd_t          rd,
    output mtnc_res_t         res
);

    phase_t              phase_reg, phase_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [CI_W-1:0]     ci_reg, ci_next;
    logic                match_reg, match_next;
    status_t             err_reg, err_next;

    logic                blank;
    logic                end_byte;
    logic [CI_W-1:0]     ci_eff;
    status_t             code;
    status_t             st;
    logic [STACK_AW-1:0] rd_top;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_OUTSIDE;
            count_reg <= '0;
            ci_reg    <= '0;
            match_reg <= 1'b1;
            err_reg   <= ST_OK;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            ci_reg    <= ci_next;
            match_reg <= match_next;
            err_reg   <= err_next;
        end
    end

    // byte decode and next state
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        ci_next    = ci_reg;
        match_next = match_reg;
        err_next   = err_reg;
        code       = ST_OK;
        wr         = '0;

        blank    = (data_byte == CH_SPACE) || (data_byte == CH_TAB) ||
                   (data_byte == CH_LF) || (data_byte == CH_CR);
        end_byte = (data_byte == CH_GT) || blank;
        ci_eff   = (phase_reg == PH_START) ? '0 : ci_reg;

        if (step)
        begin
            case (phase_reg)
                PH_OUTSIDE:
                begin
                    if (data_byte == CH_LT)
                    begin
                        phase_next = PH_START;
                    end
                end
                PH_START, PH_OPEN:
                begin
                    if (phase_reg == PH_START)
                    begin
                        ci_next    = '0;
                        match_next = 1'b1;
                    end
                    if (phase_reg == PH_START && data_byte == CH_SLASH)
                    begin
                        if (count_reg == '0)
                        begin
                            code       = ST_EMPTY_CLOSE;
                            phase_next = PH_SKIP;
                        end
                        else
                        begin
                            phase_next = PH_CLOSE;
                        end
                    end
                    else if (phase_reg == PH_START && count_reg >= COUNT_FULL)
                    begin
                        code       = ST_OVERFLOW;
                        phase_next = (data_byte == CH_GT) ? PH_OUTSIDE : PH_SKIP;
                    end
                    else if (end_byte)
                    begin
                        // name complete: record its length and push
                        wr.len_we   = 1'b1;
                        wr.len_addr = STACK_AW'(count_reg);
                        wr.len_data = ci_eff;
                        count_next  = count_reg + 1'b1;
                        phase_next  = (data_byte == CH_GT) ? PH_OUTSIDE : PH_SKIP;
                    end
                    else if (ci_eff >= NAME_LEN_CI)
                    begin
                        code       = ST_OVERFLOW;
                        phase_next = PH_SKIP;
                    end
                    else
                    begin
                        phase_next    = PH_OPEN;
                        wr.store_we   = 1'b1;
                        wr.store_addr = STORE_AW'(count_reg) * NAME_LEN_A +
                                        STORE_AW'(ci_eff);
                        wr.store_data = data_byte;
                        ci_next       = ci_eff + 1'b1;
                    end
                end
                PH_CLOSE:
                begin
                    if (end_byte)
                    begin
                        if (match_reg && ci_reg == len_rd)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                        else
                        begin
                            code = ST_MISMATCH;
                        end
                        phase_next = (data_byte == CH_GT) ? PH_OUTSIDE : PH_SKIP;
                    end
                    else
                    begin
                        if (ci_reg >= len_rd || store_rd != data_byte)
                        begin
                            match_next = 1'b0;
                        end
                        if (ci_reg < NAME_LEN_CI)
                        begin
                            ci_next = ci_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    if (data_byte == CH_GT)
                    begin
                        phase_next = PH_OUTSIDE;
                    end
                end
            endcase

            // first error wins
            if (err_reg == ST_OK)
            begin
                err_next = code;
            end
        end

        // end-of-document status, formed before the clear
        st = err_next;
        if (st == ST_OK)
        begin
            if (phase_next != PH_OUTSIDE)
            begin
                st = ST_CUT_OFF;
            end
            else if (count_next != '0)
            begin
                st = ST_UNCLOSED;
            end
        end
        res.status = st;
        res.depth  = DEPTH_W'(count_next);

        // clear for the next document
        if (step && last)
        begin
            phase_next = PH_OUTSIDE;
            count_next = '0;
            ci_next    = '0;
            match_next = 1'b1;
            err_next   = ST_OK;
        end

        // prefetch for the next byte from the state it will see
        rd_top        = STACK_AW'(count_next - 1'b1);
        rd.len_addr   = rd_top;
        rd.store_addr = STORE_AW'(rd_top) * NAME_LEN_A +
                        ((ci_next < NAME_LEN_CI) ? STORE_AW'(ci_next) : '0);
    end

    `MTNC_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= COUNT_FULL)
    `MTNC_ASSERT_IMP(a_close_has_top, phase_reg == PH_CLOSE, count_reg != '0)
    `MTNC_ASSERT_IMP(a_store_write_range, wr.store_we,
                     (count_reg < COUNT_FULL) && (ci_eff < NAME_LEN_CI))
    `MTNC_ASSERT_NEXT(a_clear_after_last, step && last,
                      (phase_reg == PH_OUTSIDE) && (count_reg == '0) && (err_reg == ST_OK))

endmodule

FILE: rtl/core/markup_tag_nesting_checker.sv
// Markup tag nesting checker: takes one document byte per cycle, sustained
// unless a last byte waits for the result to be taken, with a last flag on
// the final byte, and returns one status and open depth per document. When a
// byte is accepted the name memories (STACK_DEPTH x NAME_LEN name bytes,
// STACK_DEPTH lengths) are read at the stack top and name position the byte
// will see, and the byte is registered; the engine compares, pushes or pops
// as it advances from that register. The single read port of each memory,
// addressed from the engine's next state, sets the one-byte-per-cycle rate.
// The result sits in an output register in the cycle after the last byte is
// processed; input keeps flowing while it waits to be taken. No clearing
// pass is needed after reset: name entries are used only once pushed.
// depends on mtnc_pkg, mtnc_if, mtnc_ram and mtnc_engine
module markup_tag_nesting_checker import mtnc_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    mtnc_in_if.sink    in,
    mtnc_out_if.source out
);

    logic              p_valid_reg;
    logic [BYTE_W-1:0] p_byte_reg;
    logic              p_last_reg;
    logic              out_valid_reg;
    mtnc_res_t         res_reg;

    logic              out_free;
    logic              p_adv;
    logic              in_acc;

    mtnc_wr_t          wr;
    mtnc_rd_t          rd;
    mtnc_res_t         res;
    logic [BYTE_W-1:0] store_rd;
    logic [CI_W-1:0]   len_rd;

    // handshake
    assign out_free = !out_valid_reg || out.ready;
    assign p_adv    = p_valid_reg && (!p_last_reg || out_free);
    assign in.ready = !p_valid_reg || p_adv;
    assign in_acc   = in.valid && in.ready;

    // item stage, waiting for its memory read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            p_valid_reg <= 1'b1;
        end
        else if (p_adv)
        begin
            p_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            p_byte_reg <= in.data_byte;
            p_last_reg <= in.last;
        end
    end

    // name bytes
    mtnc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (wr.store_we),
        .waddr (wr.store_addr),
        .wdata (wr.store_data),
        .re    (in_acc),
        .raddr (rd.store_addr),
        .rdata (store_rd)
    );

    // name lengths
    mtnc_ram #(
        .WIDTH (CI_W),
        .DEPTH (STACK_DEPTH)
    ) u_len (
        .clk   (clk),
        .we    (wr.len_we),
        .waddr (wr.len_addr),
        .wdata (wr.len_data),
        .re    (in_acc),
        .raddr (rd.len_addr),
        .rdata (len_rd)
    );

    mtnc_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (p_adv),
        .data_byte (p_byte_reg),
        .last      (p_last_reg),
        .store_rd  (store_rd),
        .len_rd    (len_rd),
        .wr        (wr),
        .rd        (rd),
        .res       (res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (p_adv && p_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_adv && p_last_reg)
        begin
            res_reg <= res;
        end
    end

    assign out.valid      = out_valid_reg;
    assign out.status     = res_reg.status;
    assign out.open_depth = res_reg.depth;

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for markup_tag_nesting_checker: byte stream in, per-document status out
// depends on mtnc_pkg, mtnc_if and the checker rtl
module testbench;
    import mtnc_pkg::*;

    // one byte of stimulus, with a typed-in result where it is obvious
    typedef struct packed {
        logic [BYTE_W-1:0]  data_byte;
        logic               last;
        logic               typed;
        status_t            status;
        logic [DEPTH_W-1:0] depth;
    } byte_item_t;

    // kinds of damage done to an otherwise well-formed document
    typedef enum int {
        FLAW_NONE,
        FLAW_MISMATCH,
        FLAW_OPEN_LEFT,
        FLAW_CUT,
        FLAW_STRAY_CLOSE,
        FLAW_LONG_NAME
    } doc_flaw_t;

    localparam int GEN_DEPTH    = 6;
    localparam int TOTAL_ITEMS  = 1550;
    localparam int DEEP_AT      = 500;
    localparam int PAUSE_LATER  = 700;
    localparam int STEADY_LO    = 900;
    localparam int STEADY_HI    = 1200;
    localparam int HOLD_AFTER   = 25;
    localparam int HOLD_CYCLES  = 500;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 20;

    localparam int DIRECTED_LEN = 24;
    localparam byte_item_t DIRECTED [DIRECTED_LEN] = '{
        // no tags at all, zero byte
        '{8'h00,    1'b1, 1'b1, ST_OK,          7'd0},
        // empty name left open
        '{CH_LT,    1'b0, 1'b0, ST_OK,          7'd0},
        '{CH_GT,    1'b1, 1'b1, ST_UNCLOSED,    7'd1},
        // close with nothing open
        '{CH_LT,    1'b0, 1'b0, ST_OK,          7'd0},
        '{CH_SLASH, 1'b0, 1'b0, ST_OK,          7'd0},
        '{CH_GT,    1'b1, 1'b1, ST_EMPTY_CLOSE, 7'd0},
        // document ends inside a name
        '{CH_LT,    1'b0, 1'b0, ST_OK,          7'd0},
        '{8'h61,    1'b1, 1'b1, ST_CUT_OFF,     7'd0},
        // <a></> : empty close name against "a"
        '{CH_LT,    1'b0, 1'b0, ST_OK,          7'd0},
        '{8'h61,    1'b0, 1'b0, ST_OK,          7'd0},
        '{CH_GT,    1'b0, 1'b0, ST_OK,          7'd0},
        '{CH_LT,    1'b0, 1'b0, ST_OK,          7'd0},
        '{CH_SLASH, 1'b0, 1'b0, ST_OK,          7'd0},
        '{CH_GT,    1'b1, 1'b0, ST_OK,          7'd0},
        // name 0xff '<' ended by a tab, then closed
        '{CH_LT,    1'b0, 1'b0, ST_OK,          7'd0},
        '{8'hFF,    1'b0, 1'b0, ST_OK,          7'd0},
        '{CH_LT,    1'b0, 1'b0, ST_OK,          7'd0},
        '{CH_TAB,   1'b0, 1'b0, ST_OK,          7'd0},
        '{CH_GT,    1'b0, 1'b0, ST_OK,          7'd0},
        '{CH_LT,    1'b0, 1'b0, ST_OK,          7'd0},
        '{CH_SLASH, 1'b0, 1'b0, ST_OK,          7'd0},
        '{8'hFF,    1'b0, 1'b0, ST_OK,          7'd0},
        '{CH_LT,    1'b0, 1'b0, ST_OK,          7'd0},
        '{CH_GT,    1'b1, 1'b0, ST_OK,          7'd0}
    };

    logic clk;
    logic rst_n;

    mtnc_in_if  in_if ();
    mtnc_out_if out_if ();

    markup_tag_nesting_checker dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in_if),
        .out   (out_if)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // stimulus and scoreboard state
    byte_item_t  stream [$];
    byte_item_t  on_bus;
    mtnc_res_t   pending_results [$];
    mtnc_res_t   predicted;
    mtnc_res_t   exp_res;
    bit          got_result;
    bit          steady;
    bit          held;
    int          errors;
    int          items_taken;
    int          results_seen;
    int          quiet_cycles;
    int          status_seen [6];

    // generator nesting stack
    logic [BYTE_W-1:0] gen_names [GEN_DEPTH][NAME_LEN];
    int                gen_lens [GEN_DEPTH];
    int                gen_lvl;

    // tag tracker state
    phase_t            tag_phase;
    logic [BYTE_W-1:0] name_bytes [STORE_DEPTH];
    int                name_lens [STACK_DEPTH];
    int                open_count;
    int                name_pos;
    bit                name_equal;
    status_t           first_error;

    function automatic bit is_blank(logic [BYTE_W-1:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR;
    endfunction

    // tracker ---------------------------------------------------------------

    function automatic void clear_doc();
        tag_phase   = PH_OUTSIDE;
        open_count  = 0;
        name_pos    = 0;
        name_equal  = 1'b1;
        first_error = ST_OK;
    endfunction

    function automatic void note_error(status_t code);
        if (first_error == ST_OK)
            first_error = code;
    endfunction

    // a name ends at '>' or a blank; a blank leaves the rest of the tag to skip
    function automatic phase_t after_tag(logic [BYTE_W-1:0] b);
        if (b == CH_GT)
            return PH_OUTSIDE;
        return PH_SKIP;
    endfunction

    function automatic void open_name_byte(logic [BYTE_W-1:0] b);
        if (b == CH_GT || is_blank(b))
        begin
            name_lens[open_count] = name_pos;
            open_count++;
            tag_phase = after_tag(b);
        end
        else if (name_pos >= NAME_LEN)
        begin
            note_error(ST_OVERFLOW);
            tag_phase = PH_SKIP;
        end
        else
        begin
            name_bytes[open_count * NAME_LEN + name_pos] = b;
            name_pos++;
        end
    endfunction

    function automatic void track_byte(input logic [BYTE_W-1:0] b, input logic last,
                                       output bit done, output mtnc_res_t res);
        int top;
        done = 1'b0;
        res  = '0;
        case (tag_phase)
            PH_OUTSIDE:
            begin
                if (b == CH_LT)
                    tag_phase = PH_START;
            end
            PH_START:
            begin
                name_pos   = 0;
                name_equal = 1'b1;
                if (b == CH_SLASH)
                begin
                    if (open_count == 0)
                    begin
                        note_error(ST_EMPTY_CLOSE);
                        tag_phase = PH_SKIP;
                    end
                    else
                        tag_phase = PH_CLOSE;
                end
                else if (open_count >= STACK_DEPTH)
                begin
                    note_error(ST_OVERFLOW);
                    tag_phase = after_tag(b);
                end
                else
                begin
                    tag_phase = PH_OPEN;
                    open_name_byte(b);
                end
            end
            PH_OPEN:
                open_name_byte(b);
            PH_CLOSE:
            begin
                top = open_count - 1;
                if (b == CH_GT || is_blank(b))
                begin
                    // whole-name match pops, anything else is a mismatch
                    if (name_equal && name_pos == name_lens[top])
                        open_count = top;
                    else
                        note_error(ST_MISMATCH);
                    tag_phase = after_tag(b);
                end
                else
                begin
                    if (name_pos >= name_lens[top])
                        name_equal = 1'b0;
                    else if (name_bytes[top * NAME_LEN + name_pos] != b)
                        name_equal = 1'b0;
                    if (name_pos < NAME_LEN)
                        name_pos++;
                end
            end
            default:
            begin
                if (b == CH_GT)
                    tag_phase = PH_OUTSIDE;
            end
        endcase

        // end of document: status and depth, then start afresh
        if (last)
        begin
            done       = 1'b1;
            res.status = first_error;
            if (first_error == ST_OK)
            begin
                if (tag_phase != PH_OUTSIDE)
                    res.status = ST_CUT_OFF;
                else if (open_count != 0)
                    res.status = ST_UNCLOSED;
            end
            res.depth = DEPTH_W'(open_count);
            clear_doc();
        end
    endfunction

    // stimulus generation ---------------------------------------------------

    function automatic void put(logic [BYTE_W-1:0] b);
        byte_item_t it;
        it           = '0;
        it.data_byte = b;
        stream.push_back(it);
    endfunction

    function automatic void mark_last();
        stream[stream.size() - 1].last = 1'b1;
    endfunction

    function automatic logic [BYTE_W-1:0] name_byte(bit first);
        logic [BYTE_W-1:0] b;
        do
            b = BYTE_W'($urandom_range(255));
        while (b == CH_GT || is_blank(b) || (first && b == CH_SLASH));
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] attr_byte();
        logic [BYTE_W-1:0] b;
        do
            b = BYTE_W'($urandom_range(255));
        while (b == CH_GT);
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] text_byte();
        logic [BYTE_W-1:0] b;
        do
            b = BYTE_W'($urandom_range(255));
        while (b == CH_LT);
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] blank_byte();
        case ($urandom_range(3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    // markup characters heavily weighted
    function automatic logic [BYTE_W-1:0] noise_byte();
        int r;
        r = $urandom_range(99);
        if (r < 25)
            return CH_LT;
        if (r < 40)
            return CH_GT;
        if (r < 50)
            return CH_SLASH;
        if (r < 60)
            return blank_byte();
        return BYTE_W'($urandom_range(255));
    endfunction

    // mostly short names, now and then the longest allowed
    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(0, 3);
        if (r < 90)
            return $urandom_range(4, NAME_LEN - 1);
        return NAME_LEN;
    endfunction

    // optional attributes after a blank, then '>'
    function automatic void put_tail();
        if ($urandom_range(3) == 0)
        begin
            put(blank_byte());
            repeat ($urandom_range(0, 4))
                put(attr_byte());
        end
        put(CH_GT);
    endfunction

    // close the innermost generated tag, optionally with a wrong name
    function automatic void close_top(bit spoil);
        int                len;
        int                pos;
        int                how;
        logic [BYTE_W-1:0] b;
        gen_lvl--;
        len = gen_lens[gen_lvl];
        how = spoil ? $urandom_range(2) : 3;
        if (len == 0 && how == 0)
            how = 1;
        pos = (len > 0) ? $urandom_range(len - 1) : 0;
        put(CH_LT);
        put(CH_SLASH);
        for (int k = 0; k < len; k++)
        begin
            b = gen_names[gen_lvl][k];
            // prefix only: drop the final byte
            if (how == 0 && k == len - 1)
                break;
            if (how == 2 && k == pos)
            begin
                do
                    b = name_byte(k == 0);
                while (b == gen_names[gen_lvl][k]);
            end
            put(b);
        end
        if (how == 1 || (how == 2 && len == 0))
            put(name_byte(len == 0));
        put_tail();
    endfunction

    function automatic void gen_doc();
        doc_flaw_t flaw;
        int        steps;
        int        flaw_step;
        int        len;
        bit        bad;
        bit        spoilt;
        gen_lvl = 0;
        spoilt  = 1'b0;
        if ($urandom_range(99) < 10)
        begin
            // plain noise
            repeat ($urandom_range(1, 8))
                put(noise_byte());
        end
        else
        begin
            if ($urandom_range(99) < 60)
                flaw = FLAW_NONE;
            else
                flaw = doc_flaw_t'($urandom_range(1, 5));
            steps     = $urandom_range(1, 8);
            flaw_step = $urandom_range(0, steps - 1);
            if (flaw == FLAW_STRAY_CLOSE)
            begin
                put(CH_LT);
                put(CH_SLASH);
                repeat ($urandom_range(0, 3))
                    put(name_byte(1'b0));
                put_tail();
            end
            for (int s = 0; s < steps; s++)
            begin
                if (gen_lvl < GEN_DEPTH && (gen_lvl == 0 || $urandom_range(1) == 1))
                begin
                    // over-long name: never pushed, so the nesting stays intact
                    if (flaw == FLAW_LONG_NAME && s == flaw_step)
                    begin
                        put(CH_LT);
                        for (int k = 0; k <= NAME_LEN; k++)
                            put(name_byte(k == 0));
                        put_tail();
                    end
                    len = pick_len();
                    gen_lens[gen_lvl] = len;
                    put(CH_LT);
                    for (int k = 0; k < len; k++)
                    begin
                        gen_names[gen_lvl][k] = name_byte(k == 0);
                        put(gen_names[gen_lvl][k]);
                    end
                    put_tail();
                    gen_lvl++;
                end
                else
                begin
                    bad = (flaw == FLAW_MISMATCH) && s >= flaw_step && !spoilt;
                    close_top(bad);
                    spoilt |= bad;
                end
                if ($urandom_range(3) == 0)
                    repeat ($urandom_range(1, 3))
                        put(text_byte());
            end
            if (flaw != FLAW_OPEN_LEFT)
                while (gen_lvl > 0)
                begin
                    bad = (flaw == FLAW_MISMATCH) && !spoilt;
                    close_top(bad);
                    spoilt |= bad;
                end
            if (flaw == FLAW_CUT)
            begin
                put(CH_LT);
                if ($urandom_range(3) == 0)
                    put(CH_SLASH);
                repeat ($urandom_range(0, 3))
                    put(name_byte(1'b0));
            end
        end
        mark_last();
    endfunction

    // empty-name tags to full depth; past the depth the tags carry a name
    function automatic void gen_deep(int opens, bit close_all);
        for (int k = 0; k < opens; k++)
        begin
            put(CH_LT);
            if (k >= STACK_DEPTH)
                put(name_byte(1'b1));
            put(CH_GT);
        end
        if (close_all)
            repeat (opens)
            begin
                put(CH_LT);
                put(CH_SLASH);
                put(CH_GT);
            end
        mark_last();
    endfunction

    // monitors: prediction on accepted bytes, checking on accepted results
    always @(posedge clk)
    begin
        if (in_if.valid && in_if.ready)
        begin
            items_taken++;
            track_byte(in_if.data_byte, in_if.last, got_result, predicted);
            if (got_result)
            begin
                if (on_bus.typed)
                begin
                    predicted.status = on_bus.status;
                    predicted.depth  = on_bus.depth;
                end
                pending_results.push_back(predicted);
                status_seen[predicted.status]++;
            end
        end
        if (out_if.valid && out_if.ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: status %0d open_depth %0d",
                       out_if.status, out_if.open_depth);
                errors++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (out_if.status !== exp_res.status)
                begin
                    $error("status: expected %0d, got %0d", exp_res.status, out_if.status);
                    errors++;
                end
                if (out_if.open_depth !== exp_res.depth)
                begin
                    $error("open_depth: expected %0d, got %0d",
                           exp_res.depth, out_if.open_depth);
                    errors++;
                end
            end
        end
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    // watchdog on handshake activity
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("no handshake for %0d cycles", QUIET_LIMIT);
        $display("markup_tag_nesting_checker regression: fail");
        $finish;
    end

    // result side: random stalls, one long hold-off
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!held && results_seen >= HOLD_AFTER)
            begin
                held = 1'b1;
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(negedge clk);
            end
            else
                out_if.ready <= steady || ($urandom_range(99) >= 37);
        end
    end

    // reset, stimulus build and byte driver
    initial
    begin
        int gap;
        bit pause;
        in_if.valid     = 1'b0;
        in_if.data_byte = '0;
        in_if.last      = 1'b0;
        out_if.ready    = 1'b0;
        rst_n           = 1'b0;
        steady          = 1'b0;
        held            = 1'b0;
        errors          = 0;
        items_taken     = 0;
        results_seen    = 0;
        quiet_cycles    = 0;
        on_bus          = '0;
        foreach (status_seen[k])
            status_seen[k] = 0;
        foreach (name_bytes[k])
            name_bytes[k] = '0;
        foreach (name_lens[k])
            name_lens[k] = 0;
        clear_doc();

        // directed rows first, then random documents with the deep ones mixed in
        foreach (DIRECTED[k])
            stream.push_back(DIRECTED[k]);
        while (stream.size() < DEEP_AT)
            gen_doc();
        gen_deep(STACK_DEPTH, 1'b1);
        gen_deep(STACK_DEPTH + 1, 1'b0);
        while (stream.size() < TOTAL_ITEMS)
            gen_doc();

        repeat (3)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < stream.size(); i++)
        begin
            steady = (i >= STEADY_LO && i < STEADY_HI);
            pause  = (i == DIRECTED_LEN || i == PAUSE_LATER);
            gap    = 0;
            while (!steady && $urandom_range(99) < 37)
                gap++;
            if (gap > 0 || pause)
            begin
                in_if.valid <= 1'b0;
                repeat (gap)
                    @(negedge clk);
                // let the block drain completely
                if (pause)
                    do
                        @(negedge clk);
                    while (pending_results.size() != 0);
            end
            on_bus = stream[i];
            in_if.valid     <= 1'b1;
            in_if.data_byte <= on_bus.data_byte;
            in_if.last      <= on_bus.last;
            @(posedge clk);
            while (!in_if.ready)
                @(posedge clk);
            @(negedge clk);
        end
        in_if.valid <= 1'b0;
        steady = 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("%0d bytes accepted, %0d documents checked, nesting up to %0d and past it",
                 items_taken, results_seen, STACK_DEPTH);
        $display("statuses: ok %0d, mismatch %0d, close on empty %0d, unclosed %0d, cut-off %0d, overflow %0d",
                 status_seen[ST_OK], status_seen[ST_MISMATCH], status_seen[ST_EMPTY_CLOSE],
                 status_seen[ST_UNCLOSED], status_seen[ST_CUT_OFF], status_seen[ST_OVERFLOW]);
        if (errors == 0)
            $display("markup_tag_nesting_checker regression: pass");
        else
            $display("markup_tag_nesting_checker regression: fail");
        $finish;
    end

endmodule
